// ----- rtl/path_max_weight_independent_set_top_defines.svh -----
// assertion macros for the path independent set block
// the caller must have clk and rst_n in scope
`ifndef PATH_MAX_WEIGHT_INDEPENDENT_SET_TOP_DEFINES_SVH
`define PATH_MAX_WEIGHT_INDEPENDENT_SET_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define PMWIS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PMWIS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pmwis_pkg.sv -----
// shared types and constants for the path independent set block
// no dependencies
package pmwis_pkg;

    // parameter defaults
    localparam int MAX_ITEMS_DEF   = 64;
    localparam int WEIGHT_BITS_DEF = 16;

    // fixed port widths
    localparam int WEIGHT_W = 16;
    localparam int POS_W    = 7;
    localparam int TOTAL_W  = 22;

    // sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_TB_CHECK,
        S_TB_CMP,
        S_TB_SKIP,
        S_TB_LOAD,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } pmwis_state_t;

endpackage

// ----- rtl/pmwis_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module pmwis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/pmwis_unit.sv -----
// shared add and compare unit used by the recurrence and the traceback
// no dependencies
module pmwis_unit #(
    parameter int SUM_W = 23
) (
    input  logic [SUM_W-1:0] a,
    input  logic [SUM_W-1:0] b,
    input  logic [SUM_W-1:0] addend,
    output logic [SUM_W-1:0] max_val,
    output logic             eq
);

    logic [SUM_W-1:0] sum;

    // max(a, b + addend) and equality of the same pair
    always_comb
    begin
        sum     = b + addend;
        max_val = (a > sum) ? a : sum;
        eq      = (a == sum);
    end

endmodule

// ----- rtl/path_max_weight_independent_set_top.sv -----
// load: one weight per cycle; the best-sum recurrence runs on arrival
// traceback: steps back from the last position, comparing each best sum with the one before it
// emission: each result passes the read, load and wait states, one result at a time, and is held by any output stall
// rst_n is asynchronous active low and clears control state; memories are not swept
module path_max_weight_independent_set_top
    import pmwis_pkg::*;
#(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic                last_item,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [POS_W-1:0]    position,
    output logic [WEIGHT_W-1:0] position_weight,
    output logic                chosen,
    output logic [TOTAL_W-1:0]  best_total,
    output logic                overflowed,
    output logic                final_result
);

    localparam int W_EFF = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int SUM_W = W_EFF + CNT_W;

    pmwis_state_t        state_reg, state_next;
    logic [CNT_W-1:0]    count_reg;
    logic                ovf_reg;
    logic [SUM_W-1:0]    prev1_reg, prev2_reg;
    logic [SUM_W-1:0]    total_reg;
    logic [SUM_W-1:0]    cur_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [AW-1:0]       k_reg;
    logic                out_valid_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [WEIGHT_W-1:0] pw_reg;
    logic                chosen_reg;
    logic                final_reg;

    logic                accept, has_room, is_final, out_xfer;
    logic [SUM_W-1:0]    w_ext;
    logic [CNT_W-1:0]    idx_m1, idx_m2, idx_m3, k_pos;

    logic [SUM_W-1:0]    unit_a, unit_b, unit_add, unit_max;
    logic                unit_eq;

    logic                ram_we;
    logic                wram_re;
    logic [W_EFF-1:0]    wram_rdata;
    logic                bram_re;
    logic [AW-1:0]       bram_raddr;
    logic [SUM_W-1:0]    bram_rdata;
    logic                fram_we, fram_wdata, fram_re;
    logic [AW-1:0]       fram_waddr;
    logic [0:0]          fram_rdata;

    // handshake and index arithmetic
    assign accept   = in_valid && !in_stall;
    assign has_room = (count_reg < CNT_W'(MAX_ITEMS));
    assign w_ext    = SUM_W'(weight[W_EFF-1:0]);
    assign idx_m1   = idx_reg - CNT_W'(1);
    assign idx_m2   = idx_reg - CNT_W'(2);
    assign idx_m3   = idx_reg - CNT_W'(3);
    assign k_pos    = CNT_W'(k_reg) + CNT_W'(1);
    assign is_final = (k_pos == count_reg);
    assign out_xfer = out_valid_reg && !out_stall;
    assign ram_we   = accept && has_room;

    // shared add and compare unit
    pmwis_unit #(
        .SUM_W (SUM_W)
    ) u_unit (
        .a       (unit_a),
        .b       (unit_b),
        .addend  (unit_add),
        .max_val (unit_max),
        .eq      (unit_eq)
    );

    // weight store
    pmwis_ram #(
        .WIDTH (W_EFF),
        .DEPTH (MAX_ITEMS)
    ) u_wram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (weight[W_EFF-1:0]),
        .rd_en   (wram_re),
        .rd_addr (k_reg),
        .rd_data (wram_rdata)
    );

    // best-sum store, entry a holds best[a + 1]
    pmwis_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ITEMS)
    ) u_bram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (unit_max),
        .rd_en   (bram_re),
        .rd_addr (bram_raddr),
        .rd_data (bram_rdata)
    );

    // selection flags, every position is written by the traceback
    pmwis_ram #(
        .WIDTH (1),
        .DEPTH (MAX_ITEMS)
    ) u_fram (
        .clk     (clk),
        .wr_en   (fram_we),
        .wr_addr (fram_waddr),
        .wr_data (fram_wdata),
        .rd_en   (fram_re),
        .rd_addr (k_reg),
        .rd_data (fram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (accept && last_item)
                begin
                    state_next = S_TB_CHECK;
                end
            end
            S_TB_CHECK:
            begin
                state_next = (idx_reg >= CNT_W'(2)) ? S_TB_CMP : S_EMIT_RD;
            end
            S_TB_CMP:
            begin
                state_next = unit_eq ? S_TB_CHECK : S_TB_SKIP;
            end
            S_TB_SKIP:
            begin
                state_next = (idx_reg >= CNT_W'(3)) ? S_TB_LOAD : S_TB_CHECK;
            end
            S_TB_LOAD:
            begin
                state_next = S_TB_CHECK;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (out_xfer)
                begin
                    state_next = is_final ? S_LOAD : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // datapath controls per state
    always_comb
    begin
        unit_a     = prev1_reg;
        unit_b     = prev2_reg;
        unit_add   = w_ext;
        wram_re    = 1'b0;
        bram_re    = 1'b0;
        bram_raddr = idx_m2[AW-1:0];
        fram_we    = 1'b0;
        fram_waddr = idx_m1[AW-1:0];
        fram_wdata = 1'b0;
        fram_re    = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                unit_a   = prev1_reg;
                unit_b   = prev2_reg;
                unit_add = w_ext;
            end
            S_TB_CHECK:
            begin
                // fetch best[i-1], or settle position one
                if (idx_reg >= CNT_W'(2))
                begin
                    bram_re    = 1'b1;
                    bram_raddr = idx_m2[AW-1:0];
                end
                else if (idx_reg == CNT_W'(1))
                begin
                    fram_we    = 1'b1;
                    fram_waddr = '0;
                    fram_wdata = 1'b1;
                end
            end
            S_TB_CMP:
            begin
                // tie leaves position i out
                unit_a     = cur_reg;
                unit_b     = bram_rdata;
                unit_add   = '0;
                fram_we    = 1'b1;
                fram_waddr = idx_m1[AW-1:0];
                fram_wdata = !unit_eq;
            end
            S_TB_SKIP:
            begin
                // taking i excludes i-1, then fetch best[i-2]
                fram_we    = 1'b1;
                fram_waddr = idx_m2[AW-1:0];
                fram_wdata = 1'b0;
                if (idx_reg >= CNT_W'(3))
                begin
                    bram_re    = 1'b1;
                    bram_raddr = idx_m3[AW-1:0];
                end
            end
            S_EMIT_RD:
            begin
                wram_re = 1'b1;
                fram_re = 1'b1;
            end
            default:
            begin
                unit_a = prev1_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            prev1_reg     <= '0;
            prev2_reg     <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (has_room)
                        begin
                            prev2_reg <= prev1_reg;
                            prev1_reg <= unit_max;
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (last_item)
                        begin
                            idx_reg <= has_room ? count_reg + CNT_W'(1) : count_reg;
                            k_reg   <= '0;
                        end
                    end
                end
                S_TB_CMP:
                begin
                    if (unit_eq)
                    begin
                        idx_reg <= idx_m1;
                    end
                end
                S_TB_SKIP:
                begin
                    idx_reg <= idx_m2;
                end
                S_EMIT_LD:
                begin
                    out_valid_reg <= 1'b1;
                end
                S_EMIT_WAIT:
                begin
                    if (out_xfer)
                    begin
                        out_valid_reg <= 1'b0;
                        if (is_final)
                        begin
                            // run done, start a fresh sequence
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            prev1_reg <= '0;
                            prev2_reg <= '0;
                        end
                        else
                        begin
                            k_reg <= k_reg + AW'(1);
                        end
                    end
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && accept && last_item)
        begin
            total_reg <= has_room ? unit_max : prev1_reg;
            cur_reg   <= has_room ? unit_max : prev1_reg;
        end
        if (state_reg == S_TB_CMP && unit_eq)
        begin
            cur_reg <= bram_rdata;
        end
        if (state_reg == S_TB_LOAD)
        begin
            cur_reg <= bram_rdata;
        end
        if (state_reg == S_EMIT_LD)
        begin
            pos_reg    <= POS_W'(k_pos);
            pw_reg     <= WEIGHT_W'(wram_rdata);
            chosen_reg <= fram_rdata[0];
            final_reg  <= is_final;
        end
    end

    // ports
    assign in_stall        = (state_reg != S_LOAD);
    assign out_valid       = out_valid_reg;
    assign position        = pos_reg;
    assign position_weight = pw_reg;
    assign chosen          = chosen_reg;
    assign best_total      = TOTAL_W'(total_reg);
    assign overflowed      = ovf_reg;
    assign final_result    = final_reg;

endmodule

// ----- rtl/pmwis_chk.sv -----
// port-level checker for the path independent set block, bound to the top level
// depends on pmwis_pkg and the assertion macro header
`include "path_max_weight_independent_set_top_defines.svh"

module pmwis_chk
    import pmwis_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                last_item,
    input logic                out_valid,
    input logic                out_stall,
    input logic [POS_W-1:0]    position,
    input logic [WEIGHT_W-1:0] position_weight,
    input logic                chosen,
    input logic [TOTAL_W-1:0]  best_total,
    input logic                overflowed,
    input logic                final_result
);

    logic                                in_xfer;
    logic                                out_xfer;
    logic                                out_wait;
    logic [POS_W+WEIGHT_W+TOTAL_W+2:0]   out_bits;

    // transfer terms and the whole result payload
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign out_wait = out_valid && out_stall;
    assign out_bits = {position, position_weight, chosen, best_total, overflowed, final_result};

    // no input transfer while a result is offered
    `PMWIS_ASSERT_IMP(a_no_load_while_emit, out_valid, in_stall, "input open during emission")

    // closing transfer stops input for the traceback
    `PMWIS_ASSERT_NXT(a_close_stalls, in_xfer && last_item, in_stall, "input open after close")

    // final transfer ends the run
    `PMWIS_ASSERT_NXT(a_final_ends, out_xfer && final_result, !out_valid, "result after final")

    // a stalled result holds
    `PMWIS_ASSERT_NXT(a_out_hold, out_wait, out_valid && $stable(out_bits), "held result changed")

endmodule

bind path_max_weight_independent_set_top pmwis_chk u_chk (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// testbench for path_max_weight_independent_set_top: sends weight sequences and checks
// every per-position result against a selection predictor kept inside the bench
// depends on pmwis_pkg and the top-level rtl
module tb;
    import pmwis_pkg::*;

    localparam int CAP          = MAX_ITEMS_DEF;
    localparam int RANDOM_ITEMS = 60;
    localparam int TAIL_CYCLES  = 500;
    localparam int DRAIN_LIMIT  = 50000;
    localparam int HOLD_CYCLES  = 1500;
    localparam int PRINT_CAP    = 40;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;
    typedef enum int {W_FULL, W_SMALL, W_EXTREME} weight_kind_t;

    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [WEIGHT_W-1:0] wt;
        logic                sel;
        logic [TOTAL_W-1:0]  total;
        logic                ovf;
        logic                tail;
    } position_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [WEIGHT_W-1:0] weight = '0;
    logic                last_item = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [POS_W-1:0]    position;
    logic [WEIGHT_W-1:0] position_weight;
    logic                chosen;
    logic [TOTAL_W-1:0]  best_total;
    logic                overflowed;
    logic                final_result;

    // predictor state for the sequence being loaded
    logic [WEIGHT_W-1:0] seq_weights [CAP];
    logic [TOTAL_W:0]    best_sums [CAP+1];
    int                  seq_len = 0;
    bit                  seq_dropped = 1'b0;
    position_result_t    expected_positions [$];

    int          mismatches = 0;
    int          items_sent = 0;
    int          burst_left = 1;
    bit          gaps_on = 1'b1;
    logic        hold_on = 1'b0;
    stall_mode_t stall_mode = STALL_RANDOM;
    int          stall_phase = 0;

    path_max_weight_independent_set_top #(
        .MAX_ITEMS   (CAP),
        .WEIGHT_BITS (WEIGHT_BITS_DEF)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .weight          (weight),
        .last_item       (last_item),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .position        (position),
        .position_weight (position_weight),
        .chosen          (chosen),
        .best_total      (best_total),
        .overflowed      (overflowed),
        .final_result    (final_result)
    );

    always #5 clk = ~clk;

    function automatic void report_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("%0t mismatch: %s", $time, what);
        end
    endfunction

    // extend the best-sum table; on the closing weight trace back and queue the results
    function automatic void add_weight(logic [WEIGHT_W-1:0] w, logic closes);
        logic [TOTAL_W:0] skip_sum;
        logic [TOTAL_W:0] take_sum;
        logic [TOTAL_W:0] total;
        bit               sel [CAP];
        int               i;
        position_result_t r;
        if (seq_len < CAP)
        begin
            seq_weights[seq_len] = w;
            if (seq_len == 0)
            begin
                best_sums[1] = w;
            end
            else
            begin
                skip_sum = best_sums[seq_len];
                take_sum = best_sums[seq_len-1] + w;
                best_sums[seq_len+1] = (skip_sum > take_sum) ? skip_sum : take_sum;
            end
            seq_len++;
        end
        else
        begin
            seq_dropped = 1'b1;
        end
        if (!closes)
        begin
            return;
        end
        // traceback: a tie leaves the position out, taking one excludes its left neighbor
        for (i = 0; i < CAP; i++)
        begin
            sel[i] = 1'b0;
        end
        sel[0] = 1'b1;
        i = seq_len;
        while (i >= 2)
        begin
            if (best_sums[i] == best_sums[i-1])
            begin
                sel[i-1] = 1'b0;
                i -= 1;
            end
            else
            begin
                sel[i-1] = 1'b1;
                sel[i-2] = 1'b0;
                i -= 2;
            end
        end
        total = best_sums[seq_len];
        for (i = 0; i < seq_len; i++)
        begin
            r.pos   = POS_W'(i + 1);
            r.wt    = seq_weights[i];
            r.sel   = sel[i];
            r.total = total[TOTAL_W-1:0];
            r.ovf   = seq_dropped;
            r.tail  = (i + 1 == seq_len);
            expected_positions.push_back(r);
        end
        seq_len     = 0;
        seq_dropped = 1'b0;
        best_sums[0] = '0;
    endfunction

    function automatic void check_position();
        position_result_t want;
        if (expected_positions.size() == 0)
        begin
            report_mismatch($sformatf("result for position %0d with nothing expected", position));
            return;
        end
        want = expected_positions.pop_front();
        if (position !== want.pos)
            report_mismatch($sformatf("position: got %0d want %0d", position, want.pos));
        if (position_weight !== want.wt)
            report_mismatch($sformatf("weight at %0d: got %0d want %0d",
                                      want.pos, position_weight, want.wt));
        if (chosen !== want.sel)
            report_mismatch($sformatf("chosen at %0d: got %b want %b", want.pos, chosen, want.sel));
        if (best_total !== want.total)
            report_mismatch($sformatf("best_total at %0d: got %0d want %0d",
                                      want.pos, best_total, want.total));
        if (overflowed !== want.ovf)
            report_mismatch($sformatf("overflowed at %0d: got %b want %b",
                                      want.pos, overflowed, want.ovf));
        if (final_result !== want.tail)
            report_mismatch($sformatf("final_result at %0d: got %b want %b",
                                      want.pos, final_result, want.tail));
    endfunction

    // watch both channels; an input transfer is predicted before any output is checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                add_weight(weight, last_item);
            if (out_valid && !out_stall)
                check_position();
        end
    end

    // receiver stall pattern, overridden by a long hold-off
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (hold_on)
            out_stall <= 1'b1;
        else
        begin
            case (stall_mode)
                STALL_NONE:    out_stall <= 1'b0;
                STALL_RANDOM:  out_stall <= ($urandom_range(0, 99) < 40);
                STALL_PATTERN: out_stall <= ((stall_phase % 7) < 3);
                default:       out_stall <= 1'b0;
            endcase
        end
    end

    // one input transfer, then a random gap at the end of each burst
    task automatic send_weight(logic [WEIGHT_W-1:0] w, logic closes);
        in_valid  <= 1'b1;
        weight    <= w;
        last_item <= closes;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (gaps_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end
        end
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight(weight_kind_t kind);
        case (kind)
            W_SMALL:   return WEIGHT_W'($urandom_range(0, 3));
            W_EXTREME:
            begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return 16'h0001;
                    2:       return 16'hFFFE;
                    default: return 16'hFFFF;
                endcase
            end
            default:   return WEIGHT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_sequence(int len, weight_kind_t kind);
        int k;
        for (k = 1; k <= len; k++)
            send_weight(pick_weight(kind), k == len);
    endtask

    // sender pause until every queued result has come back or the drain limit is reached
    task automatic drain_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_positions.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // hand-picked sequences: extremes, ties, zero at position one
    task automatic test_directed();
        stall_mode <= STALL_PATTERN;
        send_weight(16'hFFFF, 1'b1);
        send_weight(16'h0000, 1'b1);
        send_weight(16'd5, 1'b0);
        send_weight(16'd5, 1'b1);
        send_weight(16'h0000, 1'b0);
        send_weight(16'h0000, 1'b0);
        send_weight(16'h0000, 1'b1);
        send_weight(16'hFFFF, 1'b0);
        send_weight(16'h0000, 1'b0);
        send_weight(16'hFFFF, 1'b1);
        send_weight(16'd1, 1'b0);
        send_weight(16'd2, 1'b0);
        send_weight(16'd3, 1'b0);
        send_weight(16'd1, 1'b1);
        send_weight(16'd3, 1'b0);
        send_weight(16'hFFFF, 1'b0);
        send_weight(16'd3, 1'b0);
        send_weight(16'h0000, 1'b0);
        send_weight(16'd1, 1'b1);
        send_weight(16'hAAAA, 1'b0);
        send_weight(16'h5555, 1'b1);
        drain_results();
    endtask

    // exactly full store with the heaviest weights
    task automatic test_full_capacity();
        int k;
        stall_mode <= STALL_RANDOM;
        for (k = 1; k <= CAP; k++)
            send_weight(16'hFFFF, k == CAP);
        drain_results();
    endtask

    // weights past capacity are dropped, including a closing one
    task automatic test_overflow();
        send_sequence(CAP + 3, W_FULL);
        send_sequence(CAP + 1, W_SMALL);
        drain_results();
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        int s;
        fork
            begin
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on <= 1'b0;
            end
        join_none
        for (s = 0; s < 6; s++)
            send_sequence($urandom_range(10, 40), W_FULL);
        drain_results();
    endtask

    // back-to-back transfers with no sender gaps and no receiver stalls
    task automatic test_steady();
        int s;
        gaps_on = 1'b0;
        stall_mode <= STALL_NONE;
        for (s = 0; s < 4; s++)
            send_sequence($urandom_range(1, 16), weight_kind_t'($urandom_range(0, 2)));
        gaps_on = 1'b1;
    endtask

    // random sequences, mostly short, some near or past capacity
    task automatic test_random();
        int start_count;
        int pick;
        int len;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(1, 12);
            else if (pick < 92)
                len = $urandom_range(13, CAP);
            else
                len = $urandom_range(CAP + 1, CAP + 6);
            stall_mode <= stall_mode_t'($urandom_range(0, 2));
            send_sequence(len, weight_kind_t'($urandom_range(0, 2)));
        end
        drain_results();
    endtask

    initial
    begin
        best_sums[0] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_capacity();
        test_overflow();
        test_backpressure();
        test_steady();
        test_random();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_positions.size() != 0)
            report_mismatch($sformatf("%0d expected results never came",
                                      expected_positions.size()));
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // run limit
    initial
    begin
        #3_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- path_max_weight_independent_set_top.f -----
+incdir+rtl
rtl/pmwis_pkg.sv
rtl/pmwis_ram.sv
rtl/pmwis_unit.sv
rtl/path_max_weight_independent_set_top.sv
rtl/pmwis_chk.sv
tb/tb.sv
